>>> sv/wrdec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrdec_pkg: shared types and codes of the receptor conductance block
// Message codes, register indexes, sequencer states and the request
// that drives the shared Q16.16 multiplier.
// ----------------------------------------------------------------------------
package wrdec_pkg;

  // Message kinds carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_POTENTIAL  = 3'd0,
    OP_ODOR       = 3'd1,
    OP_MODULATION = 3'd2,
    OP_STEP       = 3'd3,
    OP_LOAD       = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_X_GAIN     = 3'd0,
    REG_X_DECAY    = 3'd1,
    REG_Y_GAIN     = 3'd2,
    REG_Y_DECAY    = 3'd3,
    REG_PEAK_NORM  = 3'd4,
    REG_REVERSAL   = 3'd5,
    REG_TABLE_SIZE = 3'd6
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ODOR_MUL,
    S_ODOR_WAIT,
    S_ODOR_ACC,
    S_STEP_ISSUE,
    S_STEP_WAIT,
    S_SKIP
  } state_t;

  // Micro-steps of one filter time step.
  typedef enum logic [3:0] {
    U_ACT_MOD = 4'd0,
    U_DRIVE   = 4'd1,
    U_X_DECAY = 4'd2,
    U_Y_GAIN  = 4'd3,
    U_Y_DECAY = 4'd4,
    U_Y_SUM   = 4'd5,
    U_NORM    = 4'd6,
    U_CURRENT = 4'd7,
    U_FINAL   = 4'd8
  } uop_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

>>> sv/wrdec_qmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrdec_qmul: shared Q16.16 multiplier
// Two-stage unit: the exact 64-bit product is registered, then rounded
// (add one half, floor shift by 16), saturated to 32 bits and registered.
// ----------------------------------------------------------------------------
module wrdec_qmul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wrdec_pkg::mul_req_t req,
  output logic signed [31:0]       q
);
  import wrdec_pkg::*;

  logic signed [63:0] prod_r;
  logic               prod_vld_r;
  logic signed [63:0] rnd;
  logic signed [31:0] q_r;
  logic signed [31:0] q_nxt;

  // Product stage, loaded only when a request starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= req.start;
    end
    if (req.start) begin
      prod_r <= 64'(req.a) * 64'(req.b);
    end
  end

  // Rounding and saturation of the registered product.
  always_comb begin
    rnd = prod_r + 64'sd32768;
    if ((rnd[63:47] != {17{1'b0}}) && (rnd[63:47] != {17{1'b1}})) begin
      q_nxt = rnd[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      q_nxt = rnd[47:16];
    end
  end

  // The result holds until the next product arrives.
  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> sv/weighted_receptor_dual_exp_conductance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_receptor_dual_exp_conductance: odor receptor channel
// Weighted odor activation feeding a two-stage exponential conductance
// filter in saturating Q16.16, computed on one shared multiplier.
// ----------------------------------------------------------------------------
// Each request is one message selected by in_tuser. Potential, modulation,
// table-load and unknown requests leave the sequencer idle. An odor request
// with an index in range makes a registered read of the response memory
// and one pass through the two-stage shared multiplier. A time step runs
// seven dependent multiplies one after another on the shared multiplier
// and, like a skipped step, waits while the output register is full.
// After reset, and after every write that changes table_size, a clearing
// pass zeroes the response memory while in_tready is low. A finished
// result waits in the output register while the next request is accepted.
module weighted_receptor_dual_exp_conductance #(
  parameter int MAX_ODORS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] value, [47:32] odor_index
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] conductance, [63:32] channel_current
  output logic [0:0]       out_tuser,  // [0] step_skipped
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  import wrdec_pkg::*;

  localparam int          IDX_W    = (MAX_ODORS > 1) ? $clog2(MAX_ODORS) : 1;
  localparam logic [16:0] MAX_CNT  = 17'(MAX_ODORS);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_ODORS - 1);

  // Saturating adds and subtracts.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    logic signed [31:0] r;
    begin
      if (s[32] != s[31]) begin
        r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        r = s[31:0];
      end
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(33'({a[31], a}) + 33'({b[31], b}));
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(33'({a[31], a}) - 33'({b[31], b}));
  endfunction

  // Configuration registers
  logic signed [31:0] x_gain_r, x_decay_r, y_gain_r, y_decay_r;
  logic signed [31:0] peak_norm_r, reversal_r;
  logic [8:0]         table_size_r;

  // Model state
  logic signed [31:0] act_r, first_r, second_r, mod_r, pot_r, last_cond_r;
  logic               skip_r;

  // Working registers
  logic signed [31:0] val_r, diff_r, acc_r, nx_r;
  logic signed [31:0] rd_data_r;

  // Sequencer
  state_t           state_r, state_nxt;
  uop_t             uop_r, uop_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Output register
  logic               out_vld_r;
  logic signed [31:0] out_cond_r, out_cur_r;
  logic               out_skip_r;

  // Memory
  logic signed [31:0] table_mem [MAX_ODORS];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;

  // Decoded request
  logic               in_acc;
  logic signed [31:0] in_value;
  logic [15:0]        in_idx;
  logic [16:0]        used_cnt;
  logic               idx_ok, load_ok, tbl_chg, out_free, out_load;
  logic signed [31:0] q;
  mul_req_t           mul_req;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_value  = in_tdata[31:0];
  assign in_idx    = in_tdata[47:32];
  assign used_cnt  = ({8'd0, table_size_r} > MAX_CNT) ? MAX_CNT : {8'd0, table_size_r};
  assign idx_ok    = ({1'b0, in_idx} < used_cnt);
  assign load_ok   = ({1'b0, in_idx} < MAX_CNT);
  assign tbl_chg   = cfg_we && (cfg_addr == REG_TABLE_SIZE) && (cfg_wdata[8:0] != table_size_r);
  assign out_free  = !out_vld_r || out_tready;

  // Shared multiplier
  wrdec_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .q     (q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r     <= '0;
      x_decay_r    <= '0;
      y_gain_r     <= '0;
      y_decay_r    <= '0;
      peak_norm_r  <= '0;
      reversal_r   <= '0;
      table_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_GAIN:     x_gain_r     <= cfg_wdata;
        REG_X_DECAY:    x_decay_r    <= cfg_wdata;
        REG_Y_GAIN:     y_gain_r     <= cfg_wdata;
        REG_Y_DECAY:    y_decay_r    <= cfg_wdata;
        REG_PEAK_NORM:  peak_norm_r  <= cfg_wdata;
        REG_REVERSAL:   reversal_r   <= cfg_wdata;
        REG_TABLE_SIZE: table_size_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_nxt   = state_r;
    uop_nxt     = uop_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            OP_ODOR: begin
              if ((table_size_r != '0) && idx_ok) begin
                state_nxt = S_ODOR_MUL;
              end
            end
            OP_STEP: begin
              uop_nxt   = U_ACT_MOD;
              state_nxt = skip_r ? S_SKIP : S_STEP_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ODOR_MUL:  state_nxt = S_ODOR_WAIT;
      S_ODOR_WAIT: state_nxt = S_ODOR_ACC;
      S_ODOR_ACC:  state_nxt = S_IDLE;
      S_STEP_ISSUE: begin
        unique case (uop_r)
          U_Y_SUM: uop_nxt = U_NORM;
          U_FINAL: begin
            if (out_free) begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_STEP_WAIT;
        endcase
      end
      S_STEP_WAIT: begin
        state_nxt = S_STEP_ISSUE;
        uop_nxt   = uop_t'(uop_r + 4'd1);
      end
      S_SKIP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // A change of table size restarts the clearing pass.
    if (tbl_chg) begin
      state_nxt   = S_CLEAR;
      clr_cnt_nxt = '0;
    end
  end

  // Sequencer outputs: multiplier operands, memory write and result load
  always_comb begin
    mul_req   = '0;
    mem_we    = 1'b0;
    mem_waddr = in_idx[IDX_W-1:0];
    mem_wdata = in_value;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_we = in_acc && (in_tuser == OP_LOAD) && load_ok;
      end
      S_ODOR_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = val_r;
        mul_req.b     = rd_data_r;
      end
      S_STEP_ISSUE: begin
        unique case (uop_r)
          U_ACT_MOD: begin
            mul_req.start = 1'b1;
            mul_req.a     = act_r;
            mul_req.b     = mod_r;
          end
          U_DRIVE: begin
            mul_req.start = 1'b1;
            mul_req.a     = q;
            mul_req.b     = x_gain_r;
          end
          U_X_DECAY: begin
            mul_req.start = 1'b1;
            mul_req.a     = first_r;
            mul_req.b     = x_decay_r;
          end
          U_Y_GAIN: begin
            mul_req.start = 1'b1;
            mul_req.a     = first_r;
            mul_req.b     = y_gain_r;
          end
          U_Y_DECAY: begin
            mul_req.start = 1'b1;
            mul_req.a     = second_r;
            mul_req.b     = y_decay_r;
          end
          U_NORM: begin
            mul_req.start = 1'b1;
            mul_req.a     = second_r;
            mul_req.b     = peak_norm_r;
          end
          U_CURRENT: begin
            mul_req.start = 1'b1;
            mul_req.a     = diff_r;
            mul_req.b     = q;
          end
          U_FINAL: out_load = out_free;
          default: ;
        endcase
      end
      S_SKIP: out_load = out_free;
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      uop_r     <= U_ACT_MOD;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      uop_r     <= uop_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Response memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= table_mem[in_idx[IDX_W-1:0]];
  end

  // Model state and the filter datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      mod_r       <= '0;
      pot_r       <= '0;
      last_cond_r <= '0;
      skip_r      <= 1'b0;
    end else begin
      // Accepted messages
      if (in_acc) begin
        unique case (in_tuser)
          OP_POTENTIAL:  pot_r <= in_value;
          OP_MODULATION: mod_r <= in_value;
          OP_ODOR: begin
            if (table_size_r == '0) begin
              skip_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Odor accumulation once the product is ready
      if (state_r == S_ODOR_ACC) begin
        act_r <= sat_add(act_r, q);
      end
      // Filter results as they leave the multiplier
      if (state_r == S_STEP_ISSUE) begin
        unique case (uop_r)
          U_Y_SUM: begin
            first_r  <= nx_r;
            second_r <= sat_add(acc_r, q);
          end
          U_CURRENT: last_cond_r <= q;
          default: ;
        endcase
      end
      // Per-step values clear once the result is handed over.
      if (out_load) begin
        pot_r  <= '0;
        skip_r <= 1'b0;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r  <= in_value;
      diff_r <= sat_sub(reversal_r, pot_r);
    end
    if (state_r == S_STEP_ISSUE) begin
      unique case (uop_r)
        U_X_DECAY: acc_r <= q;
        U_Y_GAIN:  nx_r  <= sat_add(acc_r, q);
        U_Y_DECAY: acc_r <= q;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      out_cond_r <= last_cond_r;
      out_cur_r  <= (state_r == S_SKIP) ? 32'sd0 : q;
      out_skip_r <= (state_r == S_SKIP);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_cur_r, out_cond_r};
  assign out_tuser  = out_skip_r;

endmodule
`default_nettype wire

>>> sv/wrdec_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrdec_checker: port-level checks of the receptor conductance block
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module wrdec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [0:0]  out_tuser
);
  import wrdec_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset starts the clearing pass and drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block ready or result valid straight after reset");

  // A time step keeps the block busy in the following cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_STEP) |=> !in_tready)
    else $error("request taken straight after a time step");

  // A skipped step reports zero current.
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[63:32] == 32'd0))
    else $error("skipped step with non-zero current");

endmodule

bind weighted_receptor_dual_exp_conductance wrdec_checker u_wrdec_checker (.*);
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the odor receptor conductance block
// Sends potential, odor, modulation, table-load, time-step and spare
// requests under several register settings, and predicts every time-step
// result with a saturating Q16.16 model of its own. Each result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import wrdec_pkg::*;

  localparam int ODOR_SLOTS = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_PER_PHASE = 170;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int FIRST_SPARE_OP = 5;
  localparam int LAST_SPARE_OP = 7;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [15:0]        odor_index;
  } message_t;

  typedef struct {
    logic signed [31:0] conductance;
    logic signed [31:0] current;
    logic               skipped;
  } reading_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [31:0] value, [47:32] odor_index
  logic [2:0]  in_tuser = '0;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] conductance, [63:32] channel_current
  logic [0:0]  out_tuser;       // [0] step_skipped
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  weighted_receptor_dual_exp_conductance #(
    .MAX_ODORS(ODOR_SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Requests waiting to be sent and time-step readings still to arrive.
  message_t pending[$];
  reading_t readings[$];
  message_t in_flight;
  int       queued_count = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_cycles = 0;

  // Predicted receptor state and register copies.
  logic signed [31:0] gain_x = '0, decay_x = '0, gain_y = '0, decay_y = '0;
  logic signed [31:0] norm_g = '0, e_rev = '0;
  logic [8:0]         table_len = '0;
  logic signed [31:0] act_sum = '0, stage_x = '0, stage_y = '0, mod_level = '0;
  logic signed [31:0] v_step = '0, last_g = '0;
  logic               skip_step = 1'b0;
  logic signed [31:0] resp [0:ODOR_SLOTS-1];

  initial begin
    for (int i = 0; i < ODOR_SLOTS; i++) resp[i] = '0;
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Saturating Q16.16 arithmetic.
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > Q_MAX) return WORD_MAX;
    if (v < Q_MIN) return WORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint prod;
    prod = longint'(a) * longint'(b) + 64'sd32768;
    return clamp32(prod >>> 16);
  endfunction

  function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  // Applies one accepted request to the predicted state.
  task automatic model_message(input message_t m);
    reading_t           r;
    int                 span;
    logic signed [31:0] drive, nx, ny;
    span = (table_len > ODOR_SLOTS) ? ODOR_SLOTS : int'(table_len);
    case (m.opcode)
      OP_POTENTIAL: v_step = m.value;
      OP_MODULATION: mod_level = m.value;
      OP_ODOR: begin
        if (table_len == 0)
          skip_step = 1'b1;
        else if (m.odor_index < span)
          act_sum = q_add(act_sum, q_mul(m.value, resp[m.odor_index]));
      end
      OP_LOAD: begin
        if (m.odor_index < ODOR_SLOTS) resp[m.odor_index] = m.value;
      end
      OP_STEP: begin
        if (skip_step) begin
          r.conductance = last_g;
          r.current = '0;
          r.skipped = 1'b1;
        end else begin
          drive = q_mul(q_mul(act_sum, mod_level), gain_x);
          nx = q_add(drive, q_mul(stage_x, decay_x));
          ny = q_add(q_mul(stage_x, gain_y), q_mul(stage_y, decay_y));
          stage_x = nx;
          stage_y = ny;
          last_g = q_mul(ny, norm_g);
          r.conductance = last_g;
          r.current = q_mul(q_sub(e_rev, v_step), last_g);
          r.skipped = 1'b0;
        end
        readings.push_back(r);
        v_step = '0;
        skip_step = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Sender: takes requests from the pending queue and predicts on acceptance.
  always @(posedge clk) begin : driver
    message_t m;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) model_message(in_flight);
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          m = pending.pop_front();
          in_flight = m;
          in_tdata <= {m.odor_index, m.value};
          in_tuser <= m.opcode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and field checks against predictions.
  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (readings.size() == 0) begin
          $error("unexpected result: conductance %0d, channel_current %0d",
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
          mismatches++;
        end else begin
          want = readings.pop_front();
          if ($signed(out_tdata[31:0]) !== want.conductance) begin
            $error("conductance: expected %0d, got %0d",
                   want.conductance, $signed(out_tdata[31:0]));
            mismatches++;
          end
          if ($signed(out_tdata[63:32]) !== want.current) begin
            $error("channel_current: expected %0d, got %0d",
                   want.current, $signed(out_tdata[63:32]));
            mismatches++;
          end
          if (out_tuser[0] !== want.skipped) begin
            $error("step_skipped: expected %0d, got %0d", want.skipped, out_tuser[0]);
            mismatches++;
          end
        end
      end
    end
  end

  // Ends the run when no request, result or register write moves for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_msg(input logic [2:0] op, input logic [31:0] val,
                          input logic [15:0] idx);
    message_t m;
    m.opcode = op;
    m.value = val;
    m.odor_index = idx;
    pending.push_back(m);
    if (op < FIRST_SPARE_OP) queued_count++;
  endtask

  // Writes one register and mirrors it into the predicted copy.
  task automatic put_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_X_GAIN: gain_x = data;
      REG_X_DECAY: decay_x = data;
      REG_Y_GAIN: gain_y = data;
      REG_Y_DECAY: decay_y = data;
      REG_PEAK_NORM: norm_g = data;
      REG_REVERSAL: e_rev = data;
      REG_TABLE_SIZE: begin
        // A change of size wipes the whole response table.
        if (data[8:0] != table_len)
          for (int i = 0; i < ODOR_SLOTS; i++) resp[i] = '0;
        table_len = data[8:0];
      end
      default: ;
    endcase
  endtask

  // Waits until every request has gone and every reading has arrived,
  // lets a trailing odor request finish, and then for the block to be ready.
  task automatic settle();
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || readings.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coeff(input bit wild, input int lo, input int hi);
    if (wild) begin
      case ($urandom_range(2, 0))
        0: return WORD_MAX;
        1: return WORD_MIN;
        default: return $urandom;
      endcase
    end
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  task automatic set_up(input bit wild, input int tsize);
    put_reg(REG_X_GAIN, pick_coeff(wild, 0, 2 * ONE));
    put_reg(REG_X_DECAY, pick_coeff(wild, ONE / 4, ONE));
    put_reg(REG_Y_GAIN, pick_coeff(wild, 0, 2 * ONE));
    put_reg(REG_Y_DECAY, pick_coeff(wild, ONE / 4, ONE));
    put_reg(REG_PEAK_NORM, pick_coeff(wild, 0, 4 * ONE));
    put_reg(REG_REVERSAL, pick_coeff(wild, -80 * ONE, 80 * ONE));
    put_reg(REG_SPARE, $urandom);
    put_reg(REG_TABLE_SIZE, tsize);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly values of a few units, with full-range words and the extremes.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(7, 0))
      0: return $urandom;
      1: begin
        case ($urandom_range(3, 0))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return int'($urandom_range(4 * ONE, 0)) - 2 * ONE;
    endcase
  endfunction

  function automatic logic [15:0] pick_index(input int span);
    int r;
    r = $urandom_range(9, 0);
    if (r < 7) return (span > 0) ? $urandom_range(span - 1, 0) : $urandom_range(ODOR_SLOTS - 1, 0);
    if (r == 7) return span;
    if (r == 8) return ODOR_SLOTS - 1 + $urandom_range(1, 0);
    return $urandom_range(16'hffff, 0);
  endfunction

  // One burst: usually a well-formed step sequence, sometimes a stray request.
  task automatic queue_burst(input int span);
    int n;
    if ($urandom_range(99, 0) < 15) begin
      push_msg($urandom_range(LAST_SPARE_OP, 0), $urandom, $urandom_range(16'hffff, 0));
    end else begin
      n = $urandom_range(3, 0);
      repeat (n) push_msg(OP_LOAD, rand_q(), pick_index(span));
      if ($urandom_range(1, 0)) push_msg(OP_POTENTIAL, rand_q(), $urandom_range(16'hffff, 0));
      if ($urandom_range(3, 0) == 0)
        push_msg(OP_MODULATION, rand_q(), $urandom_range(16'hffff, 0));
      n = $urandom_range(4, 1);
      repeat (n) push_msg(OP_ODOR, rand_q(), pick_index(span));
      push_msg(OP_STEP, rand_q(), $urandom_range(16'hffff, 0));
    end
  endtask

  initial begin : stimulus
    int  tsize;
    int  span;
    bit  wild;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 51;

    // Registers at reset: empty table, so an odor request forces a skipped step.
    settle();
    push_msg(OP_STEP, 32'h0, 16'h0);
    push_msg(OP_POTENTIAL, WORD_MAX, 16'hffff);
    push_msg(OP_MODULATION, WORD_MIN, 16'h0);
    push_msg(OP_LOAD, 32'hffffffff, 16'hffff);
    for (int op = FIRST_SPARE_OP; op <= LAST_SPARE_OP; op++)
      push_msg(op, $urandom, 16'h5a5a);
    push_msg(OP_ODOR, ONE, 16'h0);
    push_msg(OP_STEP, 32'h0, 16'h0);

    // Small table with saturating extremes in weights, drive and current.
    settle();
    put_reg(REG_X_GAIN, ONE);
    put_reg(REG_X_DECAY, ONE / 2);
    put_reg(REG_Y_GAIN, ONE);
    put_reg(REG_Y_DECAY, 3 * ONE / 4);
    put_reg(REG_PEAK_NORM, WORD_MAX);
    put_reg(REG_REVERSAL, WORD_MIN);
    put_reg(REG_SPARE, 32'hdeadbeef);
    put_reg(REG_TABLE_SIZE, 4);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_msg(OP_LOAD, WORD_MAX, 16'd3);
    push_msg(OP_LOAD, WORD_MIN, 16'd0);
    push_msg(OP_LOAD, 32'h12345678, 16'd4);
    push_msg(OP_ODOR, WORD_MAX, 16'd3);
    push_msg(OP_ODOR, ONE, 16'd4);
    push_msg(OP_ODOR, WORD_MIN, 16'd0);
    push_msg(OP_MODULATION, ONE, 16'h0);
    push_msg(OP_POTENTIAL, WORD_MAX, 16'h0);
    push_msg(OP_STEP, 32'h0, 16'h0);
    push_msg(OP_STEP, 32'hffffffff, 16'hffff);
    push_msg(OP_LOAD, ONE, 16'd1);
    push_msg(OP_ODOR, -ONE, 16'd1);
    push_msg(OP_STEP, 32'h0, 16'h0);

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p / 2)
        0: begin send_idle_pct = 31; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0, 1: tsize = ODOR_SLOTS;
        2: tsize = 0;
        3: tsize = 511;
        4: tsize = $urandom_range(ODOR_SLOTS - 1, 2);
        default: tsize = 1;
      endcase
      wild = (p == 1 || p == 3);
      set_up(wild, tsize);
      span = (tsize > ODOR_SLOTS) ? ODOR_SLOTS : tsize;
      queued_count = 0;
      while (queued_count < RANDOM_PER_PHASE) queue_burst(span);
    end

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
